[rtl/wcms_pkg.sv]
// wcms_pkg: shared types and constants of the wash cycle motor sequencer
// used by wcms_cfg, wcms_core and wash_cycle_motor_sequencer_top; no dependencies

package wcms_pkg;

    localparam int unsigned SecW      = 14;  // configured duration width
    localparam int unsigned TimeW     = 17;  // elapsed seconds and phase bound width
    localparam int unsigned MsW       = 12;  // millisecond counter width
    localparam int unsigned DutyW     = 8;
    localparam int unsigned StrengthW = 2;
    localparam int unsigned CfgIdxW   = 3;
    localparam int unsigned CfgDataW  = 14;

    localparam logic [MsW-1:0]   MsMax      = 12'd4095;
    localparam logic [MsW-1:0]   ToggleMs   = 12'd2000;
    localparam logic [DutyW-1:0] WashDuty   = 8'd120;
    localparam logic [DutyW-1:0] RinseDuty  = 8'd100;
    localparam logic [DutyW-1:0] SpinLow    = 8'd100;
    localparam logic [DutyW-1:0] SpinMedium = 8'd175;
    localparam logic [DutyW-1:0] SpinHigh   = 8'd250;

    localparam logic [StrengthW-1:0] StrengthReset = 2'd1;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_FILL_SECONDS  = 3'd0,
        CFG_WASH_SECONDS  = 3'd1,
        CFG_RINSE_SECONDS = 3'd2,
        CFG_SPIN_SECONDS  = 3'd3,
        CFG_SPIN_STRENGTH = 3'd4
    } cfg_index_t;

    typedef enum logic [StrengthW-1:0] {
        STRENGTH_HOLD   = 2'd0,
        STRENGTH_LOW    = 2'd1,
        STRENGTH_MEDIUM = 2'd2,
        STRENGTH_HIGH   = 2'd3
    } strength_t;

    // phase end times of the normal cycle, precomputed from the durations
    typedef struct packed {
        logic             normal_cycle;  // fill and rinse both nonzero
        logic [TimeW-1:0] fill1_end;     // f
        logic [TimeW-1:0] wash_end;      // f + w
        logic [TimeW-1:0] drain1_end;    // w + 2f
        logic [TimeW-1:0] fill2_end;     // w + 3f
        logic [TimeW-1:0] rinse_end;     // w + 3f + r
        logic [TimeW-1:0] drain2_end;    // w + 4f + r
        logic [TimeW-1:0] spin_end;      // w + 4f + r + s
        logic [TimeW-1:0] spin_only_end; // s
        strength_t        strength;
    } cycle_bounds_t;

endpackage

[rtl/wcms_cfg.sv]
// wcms_cfg: configuration registers and registered phase end times
// depends on wcms_pkg

module wcms_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [wcms_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [wcms_pkg::CfgDataW-1:0]    cfg_data,
    output wcms_pkg::cycle_bounds_t          bounds
);

    logic [wcms_pkg::SecW-1:0]      fill_reg, wash_reg, rinse_reg, spin_reg;
    logic [wcms_pkg::StrengthW-1:0] strength_reg;
    wcms_pkg::cycle_bounds_t        bounds_reg, bounds_next;

    logic [wcms_pkg::TimeW-1:0] f, w, r, s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            wash_reg     <= '0;
            rinse_reg    <= '0;
            spin_reg     <= '0;
            strength_reg <= wcms_pkg::StrengthReset;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                wcms_pkg::CFG_FILL_SECONDS:  fill_reg  <= cfg_data;
                wcms_pkg::CFG_WASH_SECONDS:  wash_reg  <= cfg_data;
                wcms_pkg::CFG_RINSE_SECONDS: rinse_reg <= cfg_data;
                wcms_pkg::CFG_SPIN_SECONDS:  spin_reg  <= cfg_data;
                wcms_pkg::CFG_SPIN_STRENGTH:
                    strength_reg <= cfg_data[wcms_pkg::StrengthW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        f = wcms_pkg::TimeW'(fill_reg);
        w = wcms_pkg::TimeW'(wash_reg);
        r = wcms_pkg::TimeW'(rinse_reg);
        s = wcms_pkg::TimeW'(spin_reg);
        bounds_next.normal_cycle  = (fill_reg != '0) && (rinse_reg != '0);
        bounds_next.fill1_end     = f;
        bounds_next.wash_end      = f + w;
        bounds_next.drain1_end    = w + (f << 1);
        bounds_next.fill2_end     = w + (f << 1) + f;
        bounds_next.rinse_end     = w + (f << 1) + f + r;
        bounds_next.drain2_end    = w + (f << 2) + r;
        bounds_next.spin_end      = w + (f << 2) + r + s;
        bounds_next.spin_only_end = s;
        bounds_next.strength      = wcms_pkg::strength_t'(strength_reg);
    end

    // bounds are registered from the configuration registers after a write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bounds_reg <= '0;
        end else begin
            bounds_reg <= bounds_next;
        end
    end

    assign bounds = bounds_reg;

endmodule

[rtl/wcms_core.sv]
// wcms_core: input register, phase decode, motor state and result register
// depends on wcms_pkg

module wcms_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wcms_pkg::cycle_bounds_t       bounds,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_machine_enabled,
    input  logic                          s_run_request,
    input  logic [wcms_pkg::TimeW-1:0]    s_elapsed_seconds,
    input  logic                          s_ms_tick,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wcms_pkg::DutyW-1:0]    m_motor_duty,
    output logic                          m_drive_forward,
    output logic                          m_drive_reverse
);

    typedef enum logic [3:0] {
        PH_FILL1, PH_WASH, PH_DRAIN1, PH_FILL2, PH_RINSE,
        PH_DRAIN2, PH_SPIN, PH_DONE
    } phase_t;

    // input register
    logic                       in_valid_reg;
    logic                       enabled_reg, run_reg, tick_reg;
    logic [wcms_pkg::TimeW-1:0] t_reg;

    // motor state; the hold registers double as the result register
    logic                       out_valid_reg, out_valid_next;
    logic [wcms_pkg::MsW-1:0]   ms_reg, ms_next, ms_inc;
    logic                       wash_tog_reg, wash_tog_next;
    logic                       rinse_tog_reg, rinse_tog_next;
    logic [wcms_pkg::DutyW-1:0] duty_reg, duty_next;
    logic                       fwd_reg, fwd_next;
    logic                       rev_reg, rev_next;

    logic                       advance;
    phase_t                     phase;
    logic [wcms_pkg::TimeW:0]   t_plus2;
    logic                       fill1_clear, fill2_clear;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            enabled_reg <= s_machine_enabled;
            run_reg     <= s_run_request;
            t_reg       <= s_elapsed_seconds;
            tick_reg    <= s_ms_tick;
        end
    end

    // phase decode, first matching window wins
    always_comb begin
        if (!bounds.normal_cycle) begin
            phase = (t_reg < bounds.spin_only_end) ? PH_SPIN : PH_DONE;
        end else begin
            priority if (t_reg < bounds.fill1_end)  phase = PH_FILL1;
            else if (t_reg < bounds.wash_end)       phase = PH_WASH;
            else if (t_reg < bounds.drain1_end)     phase = PH_DRAIN1;
            else if (t_reg < bounds.fill2_end)      phase = PH_FILL2;
            else if (t_reg < bounds.rinse_end)      phase = PH_RINSE;
            else if (t_reg < bounds.drain2_end)     phase = PH_DRAIN2;
            else if (t_reg < bounds.spin_end)       phase = PH_SPIN;
            else                                    phase = PH_DONE;
        end
    end

    // more than two seconds before the end of a fill phase
    assign t_plus2     = {1'b0, t_reg} + (wcms_pkg::TimeW+1)'(2);
    assign fill1_clear = t_plus2 < {1'b0, bounds.fill1_end};
    assign fill2_clear = t_plus2 < {1'b0, bounds.fill2_end};

    assign ms_inc = (tick_reg && (ms_reg != wcms_pkg::MsMax)) ? ms_reg + 1'b1 : ms_reg;

    always_comb begin
        ms_next        = ms_inc;
        wash_tog_next  = wash_tog_reg;
        rinse_tog_next = rinse_tog_reg;
        duty_next      = duty_reg;
        fwd_next       = fwd_reg;
        rev_next       = rev_reg;
        if (enabled_reg) begin
            if (!run_reg) begin
                duty_next = '0;
            end else begin
                unique case (phase)
                    PH_FILL1: begin
                        duty_next = '0;
                        if (fill1_clear) ms_next = '0;
                    end
                    PH_FILL2: begin
                        duty_next = '0;
                        if (fill2_clear) ms_next = '0;
                    end
                    PH_DRAIN1, PH_DRAIN2: begin
                        duty_next = '0;
                    end
                    PH_WASH: begin
                        if (ms_inc > wcms_pkg::ToggleMs) begin
                            ms_next       = '0;
                            wash_tog_next = !wash_tog_reg;
                            fwd_next      = !wash_tog_reg;
                            rev_next      = wash_tog_reg;
                            duty_next     = wcms_pkg::WashDuty;
                        end
                    end
                    PH_RINSE: begin
                        if (ms_inc > wcms_pkg::ToggleMs) begin
                            ms_next        = '0;
                            rinse_tog_next = !rinse_tog_reg;
                            fwd_next       = !rinse_tog_reg;
                            rev_next       = rinse_tog_reg;
                            duty_next      = wcms_pkg::RinseDuty;
                        end
                    end
                    PH_SPIN: begin
                        unique case (bounds.strength)
                            wcms_pkg::STRENGTH_LOW: begin
                                fwd_next  = 1'b1;
                                rev_next  = 1'b0;
                                duty_next = wcms_pkg::SpinLow;
                            end
                            wcms_pkg::STRENGTH_MEDIUM: begin
                                fwd_next  = 1'b1;
                                rev_next  = 1'b0;
                                duty_next = wcms_pkg::SpinMedium;
                            end
                            wcms_pkg::STRENGTH_HIGH: begin
                                fwd_next  = 1'b1;
                                rev_next  = 1'b0;
                                duty_next = wcms_pkg::SpinHigh;
                            end
                            default: ;
                        endcase
                    end
                    PH_DONE: begin
                        ms_next        = '0;
                        wash_tog_next  = 1'b0;
                        rinse_tog_next = 1'b0;
                        duty_next      = '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            ms_reg        <= '0;
            wash_tog_reg  <= 1'b0;
            rinse_tog_reg <= 1'b0;
            duty_reg      <= '0;
            fwd_reg       <= 1'b0;
            rev_reg       <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                ms_reg        <= ms_next;
                wash_tog_reg  <= wash_tog_next;
                rinse_tog_reg <= rinse_tog_next;
                duty_reg      <= duty_next;
                fwd_reg       <= fwd_next;
                rev_reg       <= rev_next;
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_motor_duty    = duty_reg;
    assign m_drive_forward = fwd_reg;
    assign m_drive_reverse = rev_reg;

endmodule

[rtl/wash_cycle_motor_sequencer_top.sv]
// wash_cycle_motor_sequencer_top: top level of the wash cycle motor sequencer
// depends on wcms_pkg, wcms_cfg and wcms_core

// Motor sequencer for a washing machine cycle. Each item is one evaluation:
// the block decodes the phase (fill, wash, drain, fill, rinse, drain, spin,
// done) from elapsed_seconds and the configured durations, reverses the motor
// each time the internal millisecond counter passes 2000 during wash (duty 120)
// and rinse (duty 100), forces duty 0 in fill, drain, pause and at cycle end,
// and spins forward at the strength-selected duty. A zero fill or rinse time
// runs spin only. Every item returns exactly one result: the held duty and
// direction levels. Timing: an item is taken into the input register and
// moves on to the result register when that register is empty or being read,
// so a stall with m_ready low can hold it there; one item is taken per clock
// while m_ready is high. The limit is the single path from the input register
// through phase compare and state update into the motor state registers. The
// result register stalls with m_ready low while the input register still takes
// one more item. Configuration writes are always accepted (cfg_ready is tied
// high) and must be done while idle; the phase end times are registered from
// the written values.

module wash_cycle_motor_sequencer_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wcms_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [wcms_pkg::CfgDataW-1:0] cfg_data,
    // input items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_machine_enabled,
    input  logic                          s_run_request,
    input  logic [wcms_pkg::TimeW-1:0]    s_elapsed_seconds,
    input  logic                          s_ms_tick,
    // result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wcms_pkg::DutyW-1:0]    m_motor_duty,
    output logic                          m_drive_forward,
    output logic                          m_drive_reverse
);

    wcms_pkg::cycle_bounds_t bounds;

    // writes never stall
    assign cfg_ready = 1'b1;

    // durations, strength and precomputed phase end times
    wcms_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bounds    (bounds)
    );

    // item pipeline and motor state
    wcms_core u_core (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .bounds            (bounds),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_machine_enabled (s_machine_enabled),
        .s_run_request     (s_run_request),
        .s_elapsed_seconds (s_elapsed_seconds),
        .s_ms_tick         (s_ms_tick),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_motor_duty      (m_motor_duty),
        .m_drive_forward   (m_drive_forward),
        .m_drive_reverse   (m_drive_reverse)
    );

endmodule
